### rtl/core/psl_pkg.sv
// Package: types and constants shared by the process state list manager.
package psl_pkg;

   // Pool size and link encoding; a link equal to LINK_NONE points nowhere
   localparam int NUM_ENTRIES = 32;
   localparam int NUM_LISTS   = 3;
   localparam int IDX_W       = $clog2(NUM_ENTRIES);
   localparam int LINK_W      = $clog2(NUM_ENTRIES + 1);
   localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_ENTRIES);

   // Field widths of the stream items
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      OP_PLACE  = 2'd0,
      OP_CREATE = 2'd1,
      OP_DELETE = 2'd2,
      OP_WAIT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      LIST_READY    = 2'd0,
      LIST_FREE     = 2'd1,
      LIST_BLOCKED  = 2'd2,
      LIST_UNPLACED = 2'd3
   } list_type;

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_NOT_ON_SRC = 2'd1,
      ST_BAD_PLACE  = 2'd2,
      ST_RSVD       = 2'd3
   } status_type;

   // One request item as held in the input register
   typedef struct packed {
      op_type           op;
      logic [IDX_W-1:0] entry;
      list_type         target_list;
   } step_type;

   // One result item
   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] ready_head;
      logic             ready_nonempty;
   } result_type;

endpackage

### rtl/core/psl_store.sv
// Link store: list state registers and the single-pass unlink/append update.
module psl_store
   import psl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  step_type   step,
   output result_type result
);

   logic [NUM_ENTRIES-1:0][LINK_W-1:0] next_ff, next_in;
   logic [NUM_ENTRIES-1:0][LINK_W-1:0] prev_ff, prev_in;
   list_type [NUM_ENTRIES-1:0]         member_ff, member_in;
   logic [NUM_LISTS-1:0][LINK_W-1:0]   head_ff, head_in;
   logic [NUM_LISTS-1:0][LINK_W-1:0]   tail_ff, tail_in;

   logic [IDX_W-1:0]  e_idx;
   logic [LINK_W-1:0] e_link;
   logic              in_range;
   list_type          mem_e;
   logic [LINK_W-1:0] p_link, n_link, t_link;
   logic              p_none, n_none, t_none;
   list_type          src, dst, dst_idx;
   logic              ok;
   logic              do_unlink, do_append;
   status_type        status;
   logic [LINK_W-1:0] rh;

   // Decode: source/target lists and validity of the request
   always_comb begin
      e_idx    = step.entry;
      e_link   = {1'b0, step.entry};
      in_range = e_link < LINK_NONE;
      mem_e    = member_ff[e_idx];
      p_link   = prev_ff[e_idx];
      n_link   = next_ff[e_idx];
      src      = LIST_READY;
      dst      = LIST_FREE;
      ok       = 1'b0;
      status   = ST_DONE;
      case (step.op)
         OP_PLACE: begin
            dst    = step.target_list;
            ok     = in_range && (step.target_list != LIST_UNPLACED) &&
                     (mem_e == LIST_UNPLACED);
            status = ok ? ST_DONE : ST_BAD_PLACE;
         end
         OP_CREATE: begin
            src = LIST_FREE;
            dst = LIST_READY;
         end
         OP_DELETE: begin
            src = LIST_READY;
            dst = LIST_FREE;
         end
         default: begin
            src = LIST_READY;
            dst = LIST_BLOCKED;
         end
      endcase
      if (step.op != OP_PLACE) begin
         ok     = in_range && (mem_e == src);
         status = ok ? ST_DONE : ST_NOT_ON_SRC;
      end
      // unplaced code never indexes the head/tail arrays
      dst_idx   = (dst == LIST_UNPLACED) ? LIST_READY : dst;
      t_link    = tail_ff[dst_idx];
      p_none    = p_link >= LINK_NONE;
      n_none    = n_link >= LINK_NONE;
      t_none    = t_link >= LINK_NONE;
      do_append = step_valid && ok;
      do_unlink = do_append && (step.op != OP_PLACE);
   end

   // Per-entry link updates; the entry itself takes its append links last
   always_comb begin
      next_in   = next_ff;
      prev_in   = prev_ff;
      member_in = member_ff;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         if (do_unlink && !p_none && (p_link == LINK_W'(i)))
            next_in[i] = n_link;
         if (do_unlink && !n_none && (n_link == LINK_W'(i)))
            prev_in[i] = p_link;
         if (do_append && !t_none && (t_link == LINK_W'(i)))
            next_in[i] = e_link;
         if (do_append && (e_link == LINK_W'(i))) begin
            next_in[i]   = LINK_NONE;
            prev_in[i]   = t_link;
            member_in[i] = dst;
         end
      end
   end

   // Head and tail updates
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (do_unlink) begin
         if (p_none) head_in[src] = n_link;
         if (n_none) tail_in[src] = p_link;
      end
      if (do_append) begin
         if (t_none) head_in[dst_idx] = e_link;
         tail_in[dst_idx] = e_link;
      end
   end

   // Result reflects the ready list after this step
   always_comb begin
      rh                    = head_in[LIST_READY];
      result.status         = status;
      result.ready_nonempty = rh < LINK_NONE;
      result.ready_head     = result.ready_nonempty ? rh[IDX_W-1:0] : '0;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            next_ff[i]   <= LINK_NONE;
            prev_ff[i]   <= LINK_NONE;
            member_ff[i] <= LIST_UNPLACED;
         end
         for (int l = 0; l < NUM_LISTS; l++) begin
            head_ff[l] <= LINK_NONE;
            tail_ff[l] <= LINK_NONE;
         end
      end else if (step_valid) begin
         next_ff   <= next_in;
         prev_ff   <= prev_in;
         member_ff <= member_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
      end
   end

   // A list is empty at its head exactly when it is empty at its tail
   a_head_tail_empty: assert property (@(posedge clock) disable iff (reset)
      ((head_ff[LIST_READY] == LINK_NONE) == (tail_ff[LIST_READY] == LINK_NONE)) &&
      ((head_ff[LIST_FREE] == LINK_NONE) == (tail_ff[LIST_FREE] == LINK_NONE)) &&
      ((head_ff[LIST_BLOCKED] == LINK_NONE) == (tail_ff[LIST_BLOCKED] == LINK_NONE)))
      else $error("list head/tail emptiness disagree");

   // A good step leaves the entry at the tail of its target list
   a_append_tail: assert property (@(posedge clock) disable iff (reset)
      step_valid && ok |=> tail_ff[$past(dst_idx)] == $past(e_link))
      else $error("entry not at target tail after step");

   // A rejected step changes no membership or heads
   a_reject_stable: assert property (@(posedge clock) disable iff (reset)
      step_valid && !ok |=> $stable(member_ff) && $stable(head_ff) && $stable(tail_ff))
      else $error("rejected step changed list state");

endmodule

### rtl/core/process_state_list_manager_core.sv
// Top level: stream handshake, input and result registers around the link store.
// Each item is held in the input register, then in the result register, before its result
// is presented; a stalled result side holds it in the input register.
// Throughput: one item per cycle while the result side keeps taking items.
// The list update is one pass over the link registers between the two stages.
// Reset (synchronous, active high) empties all three lists and unplaces every entry.
module process_state_list_manager_core
   import psl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // op[1:0], entry[6:2], target_list[8:7], zeros
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // status[1:0], ready_head[6:2], ready_nonempty[7]
);

   logic       in_vld_ff, in_vld_in;
   step_type   step_ff;
   logic       out_vld_ff, out_vld_in;
   result_type result_ff;
   result_type result;
   logic       fire;
   logic       req_fire;

   // Stage advance: held item moves on when the result slot is free or draining
   assign fire       = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || fire;
   assign req_fire   = req_tvalid && req_tready;
   assign in_vld_in  = req_fire ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
   assign out_vld_in = fire ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   psl_store u_store (
      .clock      (clock),
      .reset      (reset),
      .step_valid (fire),
      .step       (step_ff),
      .result     (result)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         step_ff.op          <= op_type'(req_tdata[1:0]);
         step_ff.entry       <= req_tdata[6:2];
         step_ff.target_list <= list_type'(req_tdata[8:7]);
      end
      if (fire) result_ff <= result;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {result_ff.ready_nonempty, result_ff.ready_head, result_ff.status};

   // Empty ready list always reports head zero
   a_empty_head_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !result_ff.ready_nonempty |-> result_ff.ready_head == '0)
      else $error("ready head nonzero with empty ready list");

   // A held item that cannot advance is never dropped
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !fire |=> in_vld_ff && $stable(step_ff))
      else $error("held item lost while stalled");

endmodule

### tb/sv/psl_checker.sv
// Checker for the process state list manager: link-list predictor and result compare.
module psl_checker
   import psl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // op[1:0], entry[6:2], target_list[8:7], zeros
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // status[1:0], ready_head[6:2], ready_nonempty[7]
   output int                    error_count,
   output int                    pending_count
);

   // Shadow link store: per-entry neighbours and owning list, per-list ends
   logic [LINK_W-1:0] next_of [NUM_ENTRIES];
   logic [LINK_W-1:0] prev_of [NUM_ENTRIES];
   list_type          owner   [NUM_ENTRIES];
   logic [LINK_W-1:0] head_of [NUM_LISTS];
   logic [LINK_W-1:0] tail_of [NUM_LISTS];

   result_type expected_results[$];
   int         mismatches  = 0;
   int         outstanding = 0;

   assign error_count   = mismatches;
   assign pending_count = outstanding;

   // Take an entry out of any position of its list
   function automatic void detach_entry(logic [IDX_W-1:0] e, list_type lst);
      logic [LINK_W-1:0] p;
      logic [LINK_W-1:0] n;
      p = prev_of[e];
      n = next_of[e];
      if (p == LINK_NONE) head_of[lst] = n;
      else                next_of[p[IDX_W-1:0]] = n;
      if (n == LINK_NONE) tail_of[lst] = p;
      else                prev_of[n[IDX_W-1:0]] = p;
      next_of[e] = LINK_NONE;
      prev_of[e] = LINK_NONE;
      owner[e]   = LIST_UNPLACED;
   endfunction

   // Hang an entry on the tail of a list; an empty list gets it as head too
   function automatic void attach_entry(logic [IDX_W-1:0] e, list_type lst);
      logic [LINK_W-1:0] t;
      t          = tail_of[lst];
      prev_of[e] = t;
      next_of[e] = LINK_NONE;
      if (t == LINK_NONE) head_of[lst] = LINK_W'(e);
      else                next_of[t[IDX_W-1:0]] = LINK_W'(e);
      tail_of[lst] = LINK_W'(e);
      owner[e]     = lst;
   endfunction

   // Apply one step to the shadow lists and return the ready-list summary
   function automatic result_type apply_list_step(op_type op, logic [IDX_W-1:0] e,
                                                  list_type tgt);
      result_type r;
      list_type   src;
      list_type   dst;
      r.status = ST_DONE;
      if (op == OP_PLACE) begin
         if (tgt == LIST_UNPLACED || owner[e] != LIST_UNPLACED) r.status = ST_BAD_PLACE;
         else attach_entry(e, tgt);
      end else begin
         src = (op == OP_CREATE) ? LIST_FREE : LIST_READY;
         dst = (op == OP_CREATE) ? LIST_READY : (op == OP_DELETE) ? LIST_FREE : LIST_BLOCKED;
         if (owner[e] != src) begin
            r.status = ST_NOT_ON_SRC;
         end else begin
            detach_entry(e, src);
            attach_entry(e, dst);
         end
      end
      r.ready_nonempty = (head_of[LIST_READY] != LINK_NONE);
      r.ready_head     = r.ready_nonempty ? head_of[LIST_READY][IDX_W-1:0] : '0;
      return r;
   endfunction

   // Results are compared before new items are predicted on the same edge
   always @(posedge clock) begin : watch_channels
      result_type       want;
      status_type       got_status;
      logic [IDX_W-1:0] got_head;
      logic             got_nonempty;
      if (reset) begin
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            next_of[i] = LINK_NONE;
            prev_of[i] = LINK_NONE;
            owner[i]   = LIST_UNPLACED;
         end
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_of[i] = LINK_NONE;
            tail_of[i] = LINK_NONE;
         end
         expected_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_status   = status_type'(rsp_tdata[1:0]);
            got_head     = rsp_tdata[6:2];
            got_nonempty = rsp_tdata[7];
            if (expected_results.size() == 0) begin
               $display("%0t: result item with none expected, got %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (got_status != want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, got_status);
                  mismatches++;
               end
               if (got_head != want.ready_head) begin
                  $display("%0t: ready_head expected %0d got %0d",
                           $time, want.ready_head, got_head);
                  mismatches++;
               end
               if (got_nonempty != want.ready_nonempty) begin
                  $display("%0t: ready_nonempty expected %0d got %0d",
                           $time, want.ready_nonempty, got_nonempty);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(apply_list_step(op_type'(req_tdata[1:0]),
                                                       req_tdata[6:2],
                                                       list_type'(req_tdata[8:7])));
      end
      outstanding = expected_results.size();
   end

endmodule

### tb/sv/tb_top.sv
// Testbench top: clock, reset, stimulus and verdict for the process state list manager.
module tb_top;
   import psl_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEMS_PER_PHASE = 150;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    error_count;
   int                    pending_count;

   int send_idle_pct = 36;
   int recv_idle_pct = 80;
   int stall_cycles  = 0;

   // Which list each entry should sit on, used only to steer stimulus
   list_type placement[NUM_ENTRIES];

   process_state_list_manager_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   psl_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   // Give up when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // Present one item after random gaps, hold until taken
   task automatic send_item(input op_type op, input logic [IDX_W-1:0] e, input list_type tgt);
      @(negedge clock);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {7'd0, tgt, e, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_PLACE) begin
         if (tgt != LIST_UNPLACED && placement[e] == LIST_UNPLACED) placement[e] = tgt;
      end else if (op == OP_CREATE && placement[e] == LIST_FREE) begin
         placement[e] = LIST_READY;
      end else if (op == OP_DELETE && placement[e] == LIST_READY) begin
         placement[e] = LIST_FREE;
      end else if (op == OP_WAIT && placement[e] == LIST_READY) begin
         placement[e] = LIST_BLOCKED;
      end
   endtask

   // Mostly legal moves on random entries; a quarter pure noise
   task automatic send_random_item();
      logic [IDX_W-1:0] e;
      op_type           op;
      list_type         tgt;
      int               roll;
      e = IDX_W'($urandom_range(NUM_ENTRIES - 1, 0));
      // blocked entries never leave, so prefer one that still can
      for (int t = 0; t < 8 && placement[e] == LIST_BLOCKED; t++)
         e = IDX_W'($urandom_range(NUM_ENTRIES - 1, 0));
      tgt  = list_type'($urandom_range(3, 0));
      op   = op_type'($urandom_range(3, 0));
      roll = $urandom_range(99, 0);
      if (roll >= 25) begin
         case (placement[e])
            LIST_UNPLACED: begin
               op   = OP_PLACE;
               roll = $urandom_range(99, 0);
               tgt  = (roll < 45) ? LIST_READY : (roll < 90) ? LIST_FREE : LIST_BLOCKED;
            end
            LIST_FREE:  op = OP_CREATE;
            LIST_READY: op = ($urandom_range(99, 0) < 85) ? OP_DELETE : OP_WAIT;
            default: ;
         endcase
      end
      send_item(op, e, tgt);
   endtask

   initial begin
      for (int i = 0; i < NUM_ENTRIES; i++) placement[i] = LIST_UNPLACED;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: moves on empty lists, bad places, head/middle/tail/single unlinks
      send_item(OP_CREATE, 5'd5,  LIST_READY);
      send_item(OP_DELETE, 5'd0,  LIST_UNPLACED);
      send_item(OP_WAIT,   5'd31, LIST_BLOCKED);
      send_item(OP_PLACE,  5'd0,  LIST_READY);
      send_item(OP_PLACE,  5'd31, LIST_READY);
      send_item(OP_PLACE,  5'd7,  LIST_FREE);
      send_item(OP_PLACE,  5'd12, LIST_BLOCKED);
      send_item(OP_PLACE,  5'd3,  LIST_UNPLACED);
      send_item(OP_PLACE,  5'd0,  LIST_FREE);
      send_item(OP_WAIT,   5'd0,  LIST_UNPLACED);
      send_item(OP_DELETE, 5'd31, LIST_READY);
      send_item(OP_CREATE, 5'd7,  LIST_BLOCKED);
      send_item(OP_PLACE,  5'd20, LIST_READY);
      send_item(OP_PLACE,  5'd21, LIST_READY);
      send_item(OP_PLACE,  5'd22, LIST_READY);
      send_item(OP_WAIT,   5'd21, LIST_FREE);
      send_item(OP_DELETE, 5'd22, LIST_UNPLACED);
      send_item(OP_WAIT,   5'd12, LIST_READY);
      send_item(OP_CREATE, 5'd20, LIST_FREE);
      send_item(OP_CREATE, 5'd31, LIST_UNPLACED);
      send_item(OP_DELETE, 5'd7,  LIST_BLOCKED);
      send_item(OP_CREATE, 5'd22, LIST_READY);
      send_item(OP_PLACE,  5'd12, LIST_BLOCKED);

      // Random: slow receiver, then slow sender, then full rate
      repeat (ITEMS_PER_PHASE) send_random_item();
      send_idle_pct = 80;
      recv_idle_pct = 36;
      repeat (ITEMS_PER_PHASE) send_random_item();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (ITEMS_PER_PHASE) send_random_item();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

### files.f
rtl/core/psl_pkg.sv
rtl/core/psl_store.sv
rtl/core/process_state_list_manager_core.sv
tb/sv/psl_checker.sv
tb/sv/tb_top.sv
